// ----- rtl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the checker file pfc_checker.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked while reset is asserted
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, active during reset as well
`define ASSERT_NEXT(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- rtl/pfc_pkg.sv -----
// ---------------------------------------------------------------------------
// pfc_pkg
// Types and constants of the per-flow packet and byte counter.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package pfc_pkg;

  localparam int MAX_FLOWS   = 256;
  localparam int IDX_W       = $clog2(MAX_FLOWS);
  localparam int CNT_W       = IDX_W + 1;
  localparam int KEY_W       = 64;
  localparam int CTR_W       = 64;
  localparam int LEN_W       = 16;
  localparam int SLOT_W      = 8;
  localparam int MODE_W      = 2;
  localparam int STAT_W      = 3;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [MODE_W-1:0] MODE_COUNT    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_READ     = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR    = 2'd2;
  localparam logic [MODE_W-1:0] MODE_READ_ALT = 2'd3;

  localparam logic [STAT_W-1:0] STAT_EXISTING = 3'd0;
  localparam logic [STAT_W-1:0] STAT_NEW      = 3'd1;
  localparam logic [STAT_W-1:0] STAT_DROPPED  = 3'd2;
  localparam logic [STAT_W-1:0] STAT_READ     = 3'd3;
  localparam logic [STAT_W-1:0] STAT_CLEARED  = 3'd4;

  typedef enum logic [1:0] {
    OP_COUNT,
    OP_READ,
    OP_CLEAR
  } pfc_op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_READ,
    S_UPDATE
  } pfc_state_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [KEY_W-1:0]  flow_id;
    logic [LEN_W-1:0]  packet_length;
    logic [SLOT_W-1:0] slot_index;
  } pfc_req_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [SLOT_W-1:0] slot;
    logic              entry_valid;
    logic [KEY_W-1:0]  entry_flow_id;
    logic [CTR_W-1:0]  entry_packets;
    logic [CTR_W-1:0]  entry_bytes;
  } pfc_res_t;

  typedef struct packed {
    pfc_op_t           op;
    logic [KEY_W-1:0]  flow_id;
    logic [LEN_W-1:0]  len;
    logic [SLOT_W-1:0] slot_index;
  } pfc_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } pfc_qstat_t;

endpackage

// ----- rtl/pfc_ram.sv -----
// ---------------------------------------------------------------------------
// pfc_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pfc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/pfc_front.sv -----
// ---------------------------------------------------------------------------
// pfc_front
// Request intake: handshake and decode of the mode into a queued command.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pfc_front import pfc_pkg::*; (
  input  logic       start,
  input  pfc_req_t   in_item,
  input  pfc_qstat_t qstat,
  output logic       busy,
  output logic       push,
  output pfc_cmd_t   cmd
);

  always_comb begin
    busy           = qstat.full;
    push           = start && !qstat.full;
    cmd.flow_id    = in_item.flow_id;
    cmd.len        = in_item.packet_length;
    cmd.slot_index = in_item.slot_index;
    unique case (in_item.mode) inside
      MODE_COUNT:               cmd.op = OP_COUNT;
      MODE_READ, MODE_READ_ALT: cmd.op = OP_READ;
      MODE_CLEAR:               cmd.op = OP_CLEAR;
      default:                  cmd.op = OP_COUNT;
    endcase
  end

endmodule

// ----- rtl/pfc_queue.sv -----
// ---------------------------------------------------------------------------
// pfc_queue
// Short command queue between the intake and the table engine.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pfc_queue import pfc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  pfc_cmd_t   push_data,
  input  logic       pop,
  output pfc_cmd_t   head,
  output pfc_qstat_t qstat
);

  pfc_cmd_t          entry_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   fill_r, fill_nxt;
  logic              do_push, do_pop;

  always_comb begin
    qstat.empty = (fill_r == '0);
    qstat.full  = (fill_r == (QPTR_W+1)'(QUEUE_DEPTH));
    head        = entry_r[rd_ptr_r];
    do_push     = push && !qstat.full;
    do_pop      = pop && !qstat.empty;
    wr_ptr_nxt  = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt  = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    fill_nxt    = fill_r;
    if (do_push && !do_pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (do_pop && !do_push) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ----- rtl/pfc_back.sv -----
// ---------------------------------------------------------------------------
// pfc_back
// Table engine: key scan, counter update, slot read and counter clear.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pfc_back import pfc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  pfc_qstat_t qstat,
  input  pfc_cmd_t   head,
  output logic       pop,
  output logic       out_valid,
  output pfc_res_t   out_result
);

  pfc_state_t           state_r, state_nxt;
  pfc_cmd_t             cur_r, cur_nxt;
  logic [CNT_W-1:0]     next_free_r, next_free_nxt;
  logic [CNT_W-1:0]     scan_addr_r, scan_addr_nxt;
  logic                 cmp_vld_r, cmp_vld_nxt;
  logic [IDX_W-1:0]     cmp_idx_r, cmp_idx_nxt;
  logic [IDX_W-1:0]     hit_idx_r, hit_idx_nxt;
  logic [MAX_FLOWS-1:0] live_r, live_nxt;
  logic                 out_valid_r, out_valid_nxt;
  pfc_res_t             out_res_r, out_res_nxt;

  logic             key_we, ctr_we;
  logic [IDX_W-1:0] key_raddr, ctr_raddr, ctr_waddr, nf_idx, rd_idx;
  logic [KEY_W-1:0] key_rdata;
  logic [CTR_W-1:0] pkt_rdata, byte_rdata, pkt_wdata, byte_wdata;
  logic [CTR_W-1:0] old_pkts, old_bytes;
  logic             rd_used;

  pfc_ram #(.WIDTH(KEY_W), .DEPTH(MAX_FLOWS)) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (nf_idx),
    .wdata (cur_r.flow_id),
    .raddr (key_raddr),
    .rdata (key_rdata)
  );

  pfc_ram #(.WIDTH(CTR_W), .DEPTH(MAX_FLOWS)) u_pkt_ram (
    .clk   (clk),
    .we    (ctr_we),
    .waddr (ctr_waddr),
    .wdata (pkt_wdata),
    .raddr (ctr_raddr),
    .rdata (pkt_rdata)
  );

  pfc_ram #(.WIDTH(CTR_W), .DEPTH(MAX_FLOWS)) u_byte_ram (
    .clk   (clk),
    .we    (ctr_we),
    .waddr (ctr_waddr),
    .wdata (byte_wdata),
    .raddr (ctr_raddr),
    .rdata (byte_rdata)
  );

  assign out_valid  = out_valid_r;
  assign out_result = out_res_r;

  always_comb begin
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    next_free_nxt = next_free_r;
    scan_addr_nxt = scan_addr_r;
    cmp_vld_nxt   = cmp_vld_r;
    cmp_idx_nxt   = cmp_idx_r;
    hit_idx_nxt   = hit_idx_r;
    live_nxt      = live_r;
    out_valid_nxt = 1'b0;
    out_res_nxt   = out_res_r;
    pop           = 1'b0;
    key_we        = 1'b0;
    ctr_we        = 1'b0;

    nf_idx    = IDX_W'(next_free_r);
    rd_idx    = IDX_W'(cur_r.slot_index);
    rd_used   = (32'(cur_r.slot_index) < 32'(next_free_r));
    key_raddr = IDX_W'(scan_addr_r);
    ctr_raddr = cmp_idx_r;
    ctr_waddr = nf_idx;
    old_pkts  = live_r[hit_idx_r] ? pkt_rdata : '0;
    old_bytes = live_r[hit_idx_r] ? byte_rdata : '0;
    pkt_wdata  = CTR_W'(1);
    byte_wdata = CTR_W'(cur_r.len);

    unique case (state_r)
      S_IDLE: begin
        key_raddr = IDX_W'(head.slot_index);
        ctr_raddr = IDX_W'(head.slot_index);
        if (!qstat.empty) begin
          pop     = 1'b1;
          cur_nxt = head;
          unique case (head.op)
            OP_COUNT: begin
              scan_addr_nxt = '0;
              cmp_vld_nxt   = 1'b0;
              state_nxt     = S_SCAN;
            end
            OP_READ: begin
              state_nxt = S_READ;
            end
            OP_CLEAR: begin
              live_nxt      = '0;
              out_valid_nxt = 1'b1;
              out_res_nxt   = '0;
              out_res_nxt.status = STAT_CLEARED;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end

      S_SCAN: begin
        if (cmp_vld_r && key_rdata == cur_r.flow_id) begin
          hit_idx_nxt = cmp_idx_r;
          cmp_vld_nxt = 1'b0;
          state_nxt   = S_UPDATE;
        end else if (scan_addr_r < next_free_r) begin
          cmp_vld_nxt   = 1'b1;
          cmp_idx_nxt   = IDX_W'(scan_addr_r);
          scan_addr_nxt = scan_addr_r + 1'b1;
        end else if (cmp_vld_r) begin
          cmp_vld_nxt = 1'b0;
        end else begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          out_res_nxt   = '0;
          if (next_free_r == CNT_W'(MAX_FLOWS)) begin
            out_res_nxt.status = STAT_DROPPED;
          end else begin
            key_we                    = 1'b1;
            ctr_we                    = 1'b1;
            live_nxt[nf_idx]          = 1'b1;
            next_free_nxt             = next_free_r + 1'b1;
            out_res_nxt.status        = STAT_NEW;
            out_res_nxt.slot          = SLOT_W'(next_free_r);
            out_res_nxt.entry_valid   = 1'b1;
            out_res_nxt.entry_flow_id = cur_r.flow_id;
            out_res_nxt.entry_packets = pkt_wdata;
            out_res_nxt.entry_bytes   = byte_wdata;
          end
        end
      end

      S_READ: begin
        state_nxt                 = S_IDLE;
        out_valid_nxt             = 1'b1;
        out_res_nxt               = '0;
        out_res_nxt.status        = STAT_READ;
        out_res_nxt.slot          = cur_r.slot_index;
        out_res_nxt.entry_valid   = rd_used;
        out_res_nxt.entry_flow_id = rd_used ? key_rdata : '0;
        out_res_nxt.entry_packets = (rd_used && live_r[rd_idx]) ? pkt_rdata : '0;
        out_res_nxt.entry_bytes   = (rd_used && live_r[rd_idx]) ? byte_rdata : '0;
      end

      S_UPDATE: begin
        ctr_waddr                 = hit_idx_r;
        pkt_wdata                 = old_pkts + CTR_W'(1);
        byte_wdata                = old_bytes + CTR_W'(cur_r.len);
        ctr_we                    = 1'b1;
        live_nxt[hit_idx_r]       = 1'b1;
        state_nxt                 = S_IDLE;
        out_valid_nxt             = 1'b1;
        out_res_nxt.status        = STAT_EXISTING;
        out_res_nxt.slot          = SLOT_W'(hit_idx_r);
        out_res_nxt.entry_valid   = 1'b1;
        out_res_nxt.entry_flow_id = cur_r.flow_id;
        out_res_nxt.entry_packets = pkt_wdata;
        out_res_nxt.entry_bytes   = byte_wdata;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      next_free_r <= '0;
      cmp_vld_r   <= 1'b0;
      live_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      next_free_r <= next_free_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      live_r      <= live_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r       <= cur_nxt;
    scan_addr_r <= scan_addr_nxt;
    cmp_idx_r   <= cmp_idx_nxt;
    hit_idx_r   <= hit_idx_nxt;
    out_res_r   <= out_res_nxt;
  end

endmodule

// ----- rtl/per_flow_packet_byte_counter.sv -----
// ---------------------------------------------------------------------------
// per_flow_packet_byte_counter
// Per-flow packet and byte counter table keyed by a 64-bit flow identifier.
// ---------------------------------------------------------------------------
//  channel  | ports                  | handshake
//  request  | start, busy, in_item   | taken when start && !busy
//  result   | out_valid, out_result  | one-cycle strobe, no back-pressure
//
//  Requests wait in a two-deep queue; busy is high while it is full.
//  Count: runs the key scan (one key RAM read per cycle over the slots in
//  use), then S_UPDATE or a new entry. Read: via S_READ. Clear: from idle.
//  Synchronous active-low reset; no clearing pass, requests taken at once.
//  One result per request, in request order.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module per_flow_packet_byte_counter import pfc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  pfc_req_t in_item,
  output logic     out_valid,
  output pfc_res_t out_result
);

  pfc_qstat_t qstat;
  pfc_cmd_t   push_cmd;
  pfc_cmd_t   head;
  logic       push;
  logic       pop;

  pfc_front u_front (
    .start   (start),
    .in_item (in_item),
    .qstat   (qstat),
    .busy    (busy),
    .push    (push),
    .cmd     (push_cmd)
  );

  pfc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_cmd),
    .pop       (pop),
    .head      (head),
    .qstat     (qstat)
  );

  pfc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .qstat      (qstat),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_result (out_result)
  );

endmodule

// ----- rtl/pfc_checker.sv -----
// ---------------------------------------------------------------------------
// pfc_checker
// Port-level checks on the counter's results and busy, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pfc_checker import pfc_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     busy,
  input logic     out_valid,
  input pfc_res_t out_result
);

  `ASSERT_NEXT(a_reset_quiet, clk, !rst_n, !busy && !out_valid)

  `ASSERT_IMPL(a_new_first_packet, clk, rst_n, out_valid && out_result.status == STAT_NEW, out_result.entry_valid && out_result.entry_packets == 64'd1 && out_result.entry_bytes[63:16] == '0)

  `ASSERT_IMPL(a_no_entry_zero, clk, rst_n, out_valid && (out_result.status == STAT_DROPPED || out_result.status == STAT_CLEARED), !out_result.entry_valid && out_result.slot == '0 && out_result.entry_flow_id == '0 && out_result.entry_packets == '0 && out_result.entry_bytes == '0)

  `ASSERT_IMPL(a_empty_read_zero, clk, rst_n, out_valid && out_result.status == STAT_READ && !out_result.entry_valid, out_result.entry_flow_id == '0 && out_result.entry_packets == '0 && out_result.entry_bytes == '0)

endmodule

bind per_flow_packet_byte_counter pfc_checker u_pfc_checker (.*);

// ----- bench/per_flow_packet_byte_counter_tb.sv -----
// ---------------------------------------------------------------------------
// per_flow_packet_byte_counter_tb
// Self-checking bench for the per-flow packet and byte counter. A short
// table of directed requests covers the field extremes, every mode, the
// counter clear and reads of empty slots. Random requests then fill the
// flow table and keep counting past full so that packets get dropped.
// Results are checked in order against fixed expected values or an in-bench model of the table.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module per_flow_packet_byte_counter_tb;
  import pfc_pkg::*;

  localparam int RANDOM_PER_PHASE = 317;
  localparam int WATCHDOG_LIMIT   = 4000;
  localparam int END_PAUSE        = MAX_FLOWS + 40;

  typedef struct packed {
    pfc_req_t req;
    logic     fixed;
    pfc_res_t res;
  } stim_row_t;

  logic     clk     = 1'b0;
  logic     rst_n   = 1'b0;
  logic     start   = 1'b0;
  pfc_req_t in_item = '0;
  logic     busy;
  logic     out_valid;
  pfc_res_t out_result;

  // table model
  bit               flow_used    [MAX_FLOWS];
  logic [KEY_W-1:0] flow_key     [MAX_FLOWS];
  logic [CTR_W-1:0] flow_packets [MAX_FLOWS];
  logic [CTR_W-1:0] flow_bytes   [MAX_FLOWS];
  int unsigned      flows_in_use = 0;

  pfc_res_t    flow_results_q [$];
  stim_row_t   dir_rows [$];
  pfc_res_t    want;
  int unsigned fail_count      = 0;
  int unsigned sender_idle_pct = 0;
  int unsigned idle_cycles     = 0;

  per_flow_packet_byte_counter dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_result (out_result)
  );

  always begin
    #4;
    clk = 1'b1;
    #4;
    clk = 1'b0;
  end

  function automatic pfc_res_t update_flow_table(input pfc_req_t r);
    pfc_res_t res;
    int       hit;
    int       i;
    res = '0;
    hit = -1;
    if (r.mode == MODE_CLEAR) begin
      for (i = 0; i < MAX_FLOWS; i++) begin
        if (flow_used[i]) begin
          flow_packets[i] = '0;
          flow_bytes[i]   = '0;
        end
      end
      res.status = STAT_CLEARED;
    end else if (r.mode[0]) begin
      res.status = STAT_READ;
      res.slot   = r.slot_index;
      if (r.slot_index < MAX_FLOWS && flow_used[r.slot_index]) begin
        res.entry_valid   = 1'b1;
        res.entry_flow_id = flow_key[r.slot_index];
        res.entry_packets = flow_packets[r.slot_index];
        res.entry_bytes   = flow_bytes[r.slot_index];
      end
    end else begin
      for (i = 0; i < flows_in_use; i++) begin
        if (hit < 0 && flow_used[i] && flow_key[i] == r.flow_id) hit = i;
      end
      if (hit >= 0) begin
        flow_packets[hit] = flow_packets[hit] + CTR_W'(1);
        flow_bytes[hit]   = flow_bytes[hit] + CTR_W'(r.packet_length);
        res.status        = STAT_EXISTING;
        res.slot          = SLOT_W'(hit);
        res.entry_valid   = 1'b1;
        res.entry_flow_id = r.flow_id;
        res.entry_packets = flow_packets[hit];
        res.entry_bytes   = flow_bytes[hit];
      end else if (flows_in_use >= MAX_FLOWS) begin
        res.status = STAT_DROPPED;
      end else begin
        hit               = flows_in_use;
        flows_in_use      = flows_in_use + 1;
        flow_used[hit]    = 1'b1;
        flow_key[hit]     = r.flow_id;
        flow_packets[hit] = CTR_W'(1);
        flow_bytes[hit]   = CTR_W'(r.packet_length);
        res.status        = STAT_NEW;
        res.slot          = SLOT_W'(hit);
        res.entry_valid   = 1'b1;
        res.entry_flow_id = r.flow_id;
        res.entry_packets = CTR_W'(1);
        res.entry_bytes   = CTR_W'(r.packet_length);
      end
    end
    return res;
  endfunction

  // mostly counts, roughly half of them for new flows, so the table fills
  function automatic pfc_req_t random_request();
    pfc_req_t    r;
    int unsigned pick;
    r.mode          = MODE_COUNT;
    r.flow_id       = {$urandom, $urandom};
    r.packet_length = LEN_W'($urandom);
    r.slot_index    = SLOT_W'($urandom);
    pick = $urandom_range(99);
    if (pick < 3) begin
      r.mode = MODE_CLEAR;
    end else if (pick < 18) begin
      r.mode = (pick < 13) ? MODE_READ : MODE_READ_ALT;
      if (flows_in_use > 0 && $urandom_range(1) == 1)
        r.slot_index = SLOT_W'($urandom_range(flows_in_use - 1, 0));
    end else begin
      if (flows_in_use > 0 && $urandom_range(99) < 45)
        r.flow_id = flow_key[$urandom_range(flows_in_use - 1, 0)];
      case ($urandom_range(9))
        0: r.packet_length = '0;
        1: r.packet_length = '1;
        default: ;
      endcase
    end
    return r;
  endfunction

  function automatic stim_row_t req_row(input logic [MODE_W-1:0] mode,
                                        input logic [KEY_W-1:0] flow,
                                        input logic [LEN_W-1:0] len,
                                        input logic [SLOT_W-1:0] idx);
    stim_row_t row;
    row                   = '0;
    row.req.mode          = mode;
    row.req.flow_id       = flow;
    row.req.packet_length = len;
    row.req.slot_index    = idx;
    return row;
  endfunction

  function automatic stim_row_t fixed_row(input logic [MODE_W-1:0] mode,
                                          input logic [KEY_W-1:0] flow,
                                          input logic [LEN_W-1:0] len,
                                          input logic [SLOT_W-1:0] idx,
                                          input logic [STAT_W-1:0] status,
                                          input logic [SLOT_W-1:0] slot,
                                          input logic valid,
                                          input logic [KEY_W-1:0] key,
                                          input logic [CTR_W-1:0] pkts,
                                          input logic [CTR_W-1:0] bytes);
    stim_row_t row;
    row                   = req_row(mode, flow, len, idx);
    row.fixed             = 1'b1;
    row.res.status        = status;
    row.res.slot          = slot;
    row.res.entry_valid   = valid;
    row.res.entry_flow_id = key;
    row.res.entry_packets = pkts;
    row.res.entry_bytes   = bytes;
    return row;
  endfunction

  task automatic send_request(input pfc_req_t r, input pfc_res_t fixed_res,
                              input logic use_fixed);
    pfc_res_t predicted;
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= r;
    do @(posedge clk); while (busy !== 1'b0);
    predicted = update_flow_table(r);
    flow_results_q.push_back(use_fixed ? fixed_res : predicted);
  endtask

  task automatic wait_results_drained();
    while (flow_results_q.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [63:0] exp_v,
                             input logic [63:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %h, got %h", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) begin
      if (flow_results_q.size() == 0) begin
        $error("result with no request outstanding: %h", out_result);
        fail_count++;
      end else begin
        want = flow_results_q.pop_front();
        check_field("status", 64'(want.status), 64'(out_result.status));
        check_field("slot", 64'(want.slot), 64'(out_result.slot));
        check_field("entry_valid", 64'(want.entry_valid),
                    64'(out_result.entry_valid));
        check_field("entry_flow_id", want.entry_flow_id, out_result.entry_flow_id);
        check_field("entry_packets", want.entry_packets, out_result.entry_packets);
        check_field("entry_bytes", want.entry_bytes, out_result.entry_bytes);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && busy === 1'b0) || out_valid === 1'b1) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("** per_flow_packet_byte_counter: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int phase;
    int k;
    // empty table, extremes, both read modes, clear keeps the flows
    dir_rows.push_back(fixed_row(MODE_READ, '0, '0, 8'd0,
                                 STAT_READ, 8'd0, 1'b0, '0, '0, '0));
    dir_rows.push_back(fixed_row(MODE_COUNT, '0, '0, '0,
                                 STAT_NEW, 8'd0, 1'b1, '0, 64'd1, '0));
    dir_rows.push_back(fixed_row(MODE_COUNT, '1, '1, '0,
                                 STAT_NEW, 8'd1, 1'b1, '1, 64'd1, 64'hFFFF));
    dir_rows.push_back(fixed_row(MODE_COUNT, '0, '1, '1,
                                 STAT_EXISTING, 8'd0, 1'b1, '0, 64'd2, 64'hFFFF));
    dir_rows.push_back(fixed_row(MODE_COUNT, '1, '1, '0,
                                 STAT_EXISTING, 8'd1, 1'b1, '1, 64'd2, 64'h1FFFE));
    dir_rows.push_back(req_row(MODE_COUNT, 64'h5555_5555_5555_5555, 16'h5555, 8'h55));
    dir_rows.push_back(req_row(MODE_COUNT, 64'hAAAA_AAAA_AAAA_AAAA, 16'hAAAA, 8'hAA));
    dir_rows.push_back(req_row(MODE_COUNT, 64'h5555_5555_5555_5555, 16'hAAAA, 8'h00));
    dir_rows.push_back(fixed_row(MODE_READ, '0, '0, 8'd1,
                                 STAT_READ, 8'd1, 1'b1, '1, 64'd2, 64'h1FFFE));
    dir_rows.push_back(fixed_row(MODE_READ, '1, '1, 8'hFF,
                                 STAT_READ, 8'hFF, 1'b0, '0, '0, '0));
    dir_rows.push_back(req_row(MODE_READ_ALT, 64'h0123_4567_89AB_CDEF, 16'h1234, 8'd2));
    dir_rows.push_back(req_row(MODE_READ, '0, '0, 8'hAA));
    dir_rows.push_back(req_row(MODE_READ, 64'hAAAA_AAAA_AAAA_AAAA, 16'h5555, 8'h55));
    dir_rows.push_back(fixed_row(MODE_CLEAR, '1, '1, '1,
                                 STAT_CLEARED, 8'd0, 1'b0, '0, '0, '0));
    dir_rows.push_back(fixed_row(MODE_READ, '0, '0, 8'd0,
                                 STAT_READ, 8'd0, 1'b1, '0, '0, '0));
    dir_rows.push_back(fixed_row(MODE_READ_ALT, '0, '0, 8'd3, STAT_READ, 8'd3, 1'b1,
                                 64'hAAAA_AAAA_AAAA_AAAA, '0, '0));
    dir_rows.push_back(fixed_row(MODE_COUNT, '0, 16'd1, '0,
                                 STAT_EXISTING, 8'd0, 1'b1, '0, 64'd1, 64'd1));
    dir_rows.push_back(req_row(MODE_COUNT, 64'h8000_0000_0000_0000, 16'h8000, 8'h80));
    dir_rows.push_back(req_row(MODE_COUNT, 64'd1, 16'd0, 8'd1));
    dir_rows.push_back(fixed_row(MODE_CLEAR, '0, '0, '0,
                                 STAT_CLEARED, 8'd0, 1'b0, '0, '0, '0));
    dir_rows.push_back(req_row(MODE_READ, '0, '0, 8'd4));
    dir_rows.push_back(req_row(MODE_COUNT, 64'hAAAA_AAAA_AAAA_AAAA, '1, '0));

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    for (k = 0; k < dir_rows.size(); k++)
      send_request(dir_rows[k].req, dir_rows[k].res, dir_rows[k].fixed);

    // table fills during the random part, then unknown flows are dropped
    for (phase = 0; phase < 3; phase++) begin
      start <= 1'b0;
      wait_results_drained();
      sender_idle_pct = (phase == 0) ? 30 : (phase == 1) ? 61 : 0;
      repeat (RANDOM_PER_PHASE) send_request(random_request(), '0, 1'b0);
    end

    start <= 1'b0;
    wait_results_drained();
    repeat (END_PAUSE) @(posedge clk);
    if (fail_count == 0) begin
      $display("** per_flow_packet_byte_counter: PASSED **");
    end else begin
      $display("** per_flow_packet_byte_counter: FAILED **");
    end
    $finish;
  end

endmodule
